// File: sv/lclp_pkg.sv
// lclp_pkg: shared codes, types and keyword helpers for the laser command line parser
// used by lclp_line_proc and laser_command_line_parser; no dependencies
`default_nettype none

package lclp_pkg;

    // default coordinate precision
    localparam int COORD_BITS_DEF = 16;
    localparam int OUT_COORD_W    = 16;

    // input item kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOL  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    // result commands
    localparam logic [1:0] CMD_EOF   = 2'd0;
    localparam logic [1:0] CMD_ERROR = 2'd1;
    localparam logic [1:0] CMD_LASER = 2'd2;
    localparam logic [1:0] CMD_MOVE  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
    localparam logic [2:0] ERR_NO_ONOFF  = 3'd2;
    localparam logic [2:0] ERR_NO_COORD  = 3'd3;
    localparam logic [2:0] ERR_NO_SECOND = 3'd4;
    localparam logic [2:0] ERR_DIGIT_BOL = 3'd5;

    // digit run tracking
    localparam logic [2:0] PH_NONE    = 3'd0;
    localparam logic [2:0] PH_X       = 3'd1;
    localparam logic [2:0] PH_AFTER_X = 3'd2;
    localparam logic [2:0] PH_Y       = 3'd3;
    localparam logic [2:0] PH_AFTER_Y = 3'd4;

    // keyword found bit positions
    localparam int KW_LASER_BIT = 0;
    localparam int KW_MOVE_BIT  = 1;
    localparam int KW_ON_BIT    = 2;
    localparam int KW_OFF_BIT   = 3;

    // keywords, right aligned, first letter in the highest used byte
    localparam logic [39:0] KW_LASER = "LASER";
    localparam logic [39:0] KW_MOVE  = 40'("MOVE");
    localparam logic [39:0] KW_ON    = 40'("ON");
    localparam logic [39:0] KW_OFF   = 40'("OFF");
    localparam logic [2:0]  LEN_LASER = 3'd5;
    localparam logic [2:0]  LEN_MOVE  = 3'd4;
    localparam logic [2:0]  LEN_ON    = 3'd2;
    localparam logic [2:0]  LEN_OFF   = 3'd3;

    localparam logic [7:0] CHAR_HASH = "#";
    localparam logic [7:0] CHAR_ZERO = "0";

    typedef struct packed {
        logic       found;
        logic [2:0] pos;
    } lclp_match_t;

    typedef struct packed {
        logic                   has;
        logic [1:0]             command;
        logic                   laser_on;
        logic [OUT_COORD_W-1:0] coord_x;
        logic [OUT_COORD_W-1:0] coord_y;
        logic [2:0]             error_code;
    } lclp_result_t;

    typedef struct packed {
        logic line_nonempty;
        logic first_is_hash;
    } lclp_stat_t;

    // letter i of a keyword of length len
    function automatic logic [7:0] kw_char(input logic [39:0] kw, input logic [2:0] len,
                                           input logic [2:0] i);
        logic [2:0] shift;
        shift = len - 3'd1 - i;
        return kw[{shift, 3'b000} +: 8];
    endfunction

    // one step of a keyword matcher; no keyword has a border past its first letter
    function automatic lclp_match_t match_step(input logic [2:0] pos, input logic [7:0] c,
                                               input logic [39:0] kw, input logic [2:0] len);
        lclp_match_t r;
        logic [2:0]  p;
        p = (pos >= len) ? 3'd0 : pos;
        r.found = 1'b0;
        if (c == kw_char(kw, len, p))
        begin
            if (p + 3'd1 == len)
            begin
                r.found = 1'b1;
                r.pos   = 3'd0;
            end
            else
            begin
                r.pos = p + 3'd1;
            end
        end
        else
        begin
            r.pos = (c == kw_char(kw, len, 3'd0)) ? 3'd1 : 3'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/laser_command_line_parser.sv
// laser_command_line_parser: top level, input register, line processor and result register
// depends on lclp_pkg and lclp_line_proc
//
// Parses a text command stream one item per clock. Each input item is a character, an end
// of line or an end of file (s_tuser). Matching ignores case; a line holding LASER gives a
// laser command (ON wins over OFF), otherwise a line holding MOVE gives a move with the
// first two decimal digit runs as X and Y, saturated at 2^COORD_BITS - 1 and cut to 16
// bits, and anything else gives an error code. Empty lines and lines opening with '#' give
// nothing; end of file gives an end result and drops an unterminated line. An accepted item
// is loaded into the input register, and its result then into the result register. The
// block sustains one item per clock: the line state update and the classification are a
// single pass of logic, with one multiply-by-ten add for the digit capture. s_tready only
// drops while a result-producing item sits in the input register and the result register
// is still held by the downstream side.
`default_nettype none

module laser_command_line_parser
    import lclp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // result item stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [0] laser_on, [16:1] coord_x, [32:17] coord_y,
                                        // [35:33] error_code, [39:36] zero
    output logic [1:0]       m_tuser    // [1:0] command
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_kind_reg;
    logic [7:0] in_char_reg;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_cmd_reg;
    logic                   out_laser_reg;
    logic [OUT_COORD_W-1:0] out_x_reg;
    logic [OUT_COORD_W-1:0] out_y_reg;
    logic [2:0]             out_err_reg;

    lclp_result_t result;
    lclp_stat_t   stat;
    logic         advance;
    logic         in_take;

    // an item leaves the input register unless its result would overwrite a held one
    assign advance  = in_valid_reg && (!result.has || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    lclp_line_proc #(
        .COORD_BITS (COORD_BITS)
    ) u_line_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .kind      (in_kind_reg),
        .character (in_char_reg),
        .result    (result),
        .stat      (stat)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && result.has)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
        if (advance && result.has)
        begin
            out_cmd_reg   <= result.command;
            out_laser_reg <= result.laser_on;
            out_x_reg     <= result.coord_x;
            out_y_reg     <= result.coord_y;
            out_err_reg   <= result.error_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tdata  = {4'b0000, out_err_reg, out_y_reg, out_x_reg, out_laser_reg};

    // a move result carries no error code and no laser flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cmd_reg == CMD_MOVE |-> out_err_reg == ERR_NONE && !out_laser_reg)
        else $error("move result with stray error or laser bits");

    // an error result always names a reason
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cmd_reg == CMD_ERROR |-> out_err_reg != ERR_NONE)
        else $error("error result without a code");

    // back pressure only when a result is blocked downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready && result.has)
        else $error("input stalled without a blocked result");

    // end of file leaves an empty line behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_kind_reg == KIND_EOF |=> !stat.line_nonempty && !stat.first_is_hash)
        else $error("line state not cleared by end of file");

endmodule

`default_nettype wire

// File: sv/lclp_line_proc.sv
// lclp_line_proc: per-line state (keyword matchers, digit capture) and line classification
// depends on lclp_pkg
`default_nettype none

module lclp_line_proc
    import lclp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [1:0]   kind,
    input  wire logic [7:0]   character,
    output lclp_result_t      result,
    output lclp_stat_t        stat
);

    localparam int ACC_W = COORD_BITS + 4;
    localparam int EXT_W = (COORD_BITS > OUT_COORD_W) ? COORD_BITS : OUT_COORD_W;
    localparam logic [ACC_W-1:0] MAXV = {4'b0000, {COORD_BITS{1'b1}}};

    logic                  nonempty_reg, nonempty_next;
    logic                  hash_reg, hash_next;
    logic [2:0]            laser_pos_reg, laser_pos_next;
    logic [2:0]            move_pos_reg, move_pos_next;
    logic [1:0]            on_pos_reg, on_pos_next;
    logic [1:0]            off_pos_reg, off_pos_next;
    logic [3:0]            found_reg, found_next;
    logic [2:0]            phase_reg, phase_next;
    logic                  dstart_reg, dstart_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;

    logic [7:0]     c_up;
    logic           digit;
    logic [3:0]     dval;
    lclp_match_t    m_laser, m_move, m_on, m_off;
    logic [EXT_W-1:0] x_ext, y_ext;

    // value * 10 + digit, saturated
    function automatic logic [COORD_BITS-1:0] acc(input logic [COORD_BITS-1:0] v,
                                                  input logic [3:0] d);
        logic [ACC_W-1:0] n;
        n = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {{COORD_BITS{1'b0}}, d};
        return (n > MAXV) ? {COORD_BITS{1'b1}} : n[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        c_up  = (character inside {[8'h61:8'h7A]}) ? character - 8'd32 : character;
        digit = c_up inside {[8'h30:8'h39]};
        dval  = 4'(c_up - CHAR_ZERO);
        m_laser = match_step(laser_pos_reg, c_up, KW_LASER, LEN_LASER);
        m_move  = match_step(move_pos_reg, c_up, KW_MOVE, LEN_MOVE);
        m_on    = match_step({1'b0, on_pos_reg}, c_up, KW_ON, LEN_ON);
        m_off   = match_step({1'b0, off_pos_reg}, c_up, KW_OFF, LEN_OFF);
        x_ext   = EXT_W'(x_reg);
        y_ext   = EXT_W'(y_reg);
    end

    always_comb
    begin
        nonempty_next  = nonempty_reg;
        hash_next      = hash_reg;
        laser_pos_next = laser_pos_reg;
        move_pos_next  = move_pos_reg;
        on_pos_next    = on_pos_reg;
        off_pos_next   = off_pos_reg;
        found_next     = found_reg;
        phase_next     = phase_reg;
        dstart_next    = dstart_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        result         = '0;

        case (kind)
            KIND_CHAR:
            begin
                if (!nonempty_reg)
                begin
                    nonempty_next = 1'b1;
                    hash_next     = (c_up == CHAR_HASH);
                    dstart_next   = digit;
                end
                laser_pos_next = m_laser.pos;
                move_pos_next  = m_move.pos;
                on_pos_next    = m_on.pos[1:0];
                off_pos_next   = m_off.pos[1:0];
                found_next = found_reg | {m_off.found, m_on.found, m_move.found, m_laser.found};

                case (phase_reg)
                    PH_NONE:
                    begin
                        if (digit)
                        begin
                            x_next     = acc('0, dval);
                            phase_next = PH_X;
                        end
                    end
                    PH_X:
                    begin
                        if (digit)
                            x_next = acc(x_reg, dval);
                        else
                            phase_next = PH_AFTER_X;
                    end
                    PH_AFTER_X:
                    begin
                        if (digit)
                        begin
                            y_next     = acc('0, dval);
                            phase_next = PH_Y;
                        end
                    end
                    PH_Y:
                    begin
                        if (digit)
                            y_next = acc(y_reg, dval);
                        else
                            phase_next = PH_AFTER_Y;
                    end
                    default:
                    begin
                    end
                endcase
            end

            KIND_EOL, KIND_EOF:
            begin
                if (kind == KIND_EOF)
                begin
                    result.has     = 1'b1;
                    result.command = CMD_EOF;
                end
                else if (nonempty_reg && !hash_reg)
                begin
                    result.has = 1'b1;
                    if (found_reg[KW_LASER_BIT])
                    begin
                        if (found_reg[KW_ON_BIT] || found_reg[KW_OFF_BIT])
                        begin
                            result.command  = CMD_LASER;
                            result.laser_on = found_reg[KW_ON_BIT];
                        end
                        else
                        begin
                            result.command    = CMD_ERROR;
                            result.error_code = ERR_NO_ONOFF;
                        end
                    end
                    else if (found_reg[KW_MOVE_BIT])
                    begin
                        if (phase_reg == PH_NONE)
                        begin
                            result.command    = CMD_ERROR;
                            result.error_code = ERR_NO_COORD;
                        end
                        else if (phase_reg == PH_X || phase_reg == PH_AFTER_X)
                        begin
                            result.command    = CMD_ERROR;
                            result.error_code = ERR_NO_SECOND;
                        end
                        else if (dstart_reg)
                        begin
                            result.command    = CMD_ERROR;
                            result.error_code = ERR_DIGIT_BOL;
                        end
                        else
                        begin
                            result.command = CMD_MOVE;
                            result.coord_x = x_ext[OUT_COORD_W-1:0];
                            result.coord_y = y_ext[OUT_COORD_W-1:0];
                        end
                    end
                    else
                    begin
                        result.command    = CMD_ERROR;
                        result.error_code = ERR_UNKNOWN;
                    end
                end
                // line ends clear everything
                nonempty_next  = 1'b0;
                hash_next      = 1'b0;
                laser_pos_next = '0;
                move_pos_next  = '0;
                on_pos_next    = '0;
                off_pos_next   = '0;
                found_next     = '0;
                phase_next     = PH_NONE;
                dstart_next    = 1'b0;
                x_next         = '0;
                y_next         = '0;
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg  <= 1'b0;
            hash_reg      <= 1'b0;
            laser_pos_reg <= '0;
            move_pos_reg  <= '0;
            on_pos_reg    <= '0;
            off_pos_reg   <= '0;
            found_reg     <= '0;
            phase_reg     <= PH_NONE;
            dstart_reg    <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        else if (step)
        begin
            nonempty_reg  <= nonempty_next;
            hash_reg      <= hash_next;
            laser_pos_reg <= laser_pos_next;
            move_pos_reg  <= move_pos_next;
            on_pos_reg    <= on_pos_next;
            off_pos_reg   <= off_pos_next;
            found_reg     <= found_next;
            phase_reg     <= phase_next;
            dstart_reg    <= dstart_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
        end
    end

    assign stat.line_nonempty = nonempty_reg;
    assign stat.first_is_hash = hash_reg;

endmodule

`default_nettype wire
